// ----- design/vpbm_pkg.sv -----
`timescale 1ns / 1ps
package vpbm_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int MAX_SAMPLES = 32;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W = $clog2(MAX_SAMPLES);
    localparam int ADDR_W = ROW_W + COL_W + SLOT_W;
    localparam int PIX_W  = 24;
    localparam int QDEPTH = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_SAMPLES  = 3'd0,
        REG_MATCH_RADIUS = 3'd1,
        REG_MIN_MATCHES  = 3'd2,
        REG_UPD_INTERVAL = 3'd3,
        REG_CHANNEL_MODE = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6,
        REG_BRIGHT_MARGIN = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [5:0] num_samples;
        logic [9:0] match_radius;
        logic [5:0] min_matches;
        logic [7:0] update_interval;
        logic       channel_mode;
        logic [7:0] frame_width;
        logic [7:0] frame_height;
        logic [7:0] brightness_margin;
    } cfg_t;

    typedef enum logic [1:0] {
        K_SEED,
        K_BORDER,
        K_GATE,
        K_TEST
    } kind_t;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_MOD, S_OUT} state_t;
    typedef enum logic [1:0] {SEL_OWN_REP, SEL_OWN_SLOT, SEL_NBR_REP, SEL_NBR_SLOT} sel_t;

    typedef struct packed {
        kind_t             kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic [PIX_W-1:0]  px;
    } entry_t;

endpackage

// ----- design/vibe_pixel_background_model_top.sv -----
`timescale 1ns / 1ps
// per-pixel background model with brightness gate
// input channel s_*: valid/ready; opcode 1 seeds one sample of a pixel, opcode 0 classifies
// a pixel and may refresh its own and one neighbor sample
// result channel m_*: one beat per pixel item, none for a seed item
// config: cfg_we writes register cfg_index with cfg_data; the user must write only
// while idle, the block itself does not enforce it
// a seed item is written in the back end directly; a pixel is taken, then each stored
// sample is read then compared through the single sample memory read port until enough
// samples match or all are read, then come counter updates and sample writes (a counter
// that wraps takes one more subtraction) and the result beat; a border pixel goes
// straight to the result beat and a gated pixel skips the sample reads
// the first pixel after an update_interval or num_samples change may spend extra cycles
// wrapping the counters, one subtraction per cycle
// a registered front stage and a two-entry queue keep taking beats, until both are full,
// while the back end works or the receiver stalls; the result is held until m_ready
// reset clears handshake state, counters and registers to defaults; sample memory is
// not cleared and must be seeded before use
module vibe_pixel_background_model_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [vpbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vpbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [vpbm_pkg::ROW_W-1:0]  s_pix_row,
    input  logic [vpbm_pkg::COL_W-1:0]  s_pix_col,
    input  logic [7:0]                  s_chan_a,
    input  logic [7:0]                  s_chan_b,
    input  logic [7:0]                  s_chan_c,
    input  logic [vpbm_pkg::SLOT_W-1:0] s_seed_slot,
    input  logic [7:0]                  s_frame_mean,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_is_foreground
);
    import vpbm_pkg::*;

    cfg_t   cfg_reg;
    logic   fq_valid, fq_ready, qb_valid, qb_ready;
    entry_t fq_data, qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_samples       <= 6'd20;
            cfg_reg.match_radius      <= 10'd20;
            cfg_reg.min_matches       <= 6'd2;
            cfg_reg.update_interval   <= 8'd16;
            cfg_reg.channel_mode      <= 1'b1;
            cfg_reg.frame_width       <= 8'd128;
            cfg_reg.frame_height      <= 8'd128;
            cfg_reg.brightness_margin <= 8'd20;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_NUM_SAMPLES:  cfg_reg.num_samples       <= cfg_data[5:0];
                REG_MATCH_RADIUS: cfg_reg.match_radius      <= cfg_data[9:0];
                REG_MIN_MATCHES:  cfg_reg.min_matches       <= cfg_data[5:0];
                REG_UPD_INTERVAL: cfg_reg.update_interval   <= cfg_data[7:0];
                REG_CHANNEL_MODE: cfg_reg.channel_mode      <= cfg_data[0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width       <= cfg_data[7:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height      <= cfg_data[7:0];
                default:          cfg_reg.brightness_margin <= cfg_data[7:0];
            endcase
        end
    end

    vpbm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_pix_row    (s_pix_row),
        .s_pix_col    (s_pix_col),
        .s_chan_a     (s_chan_a),
        .s_chan_b     (s_chan_b),
        .s_chan_c     (s_chan_c),
        .s_seed_slot  (s_seed_slot),
        .s_frame_mean (s_frame_mean),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    vpbm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    vpbm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_data          (qb_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_foreground (m_is_foreground)
    );

endmodule

// ----- design/vpbm_front.sv -----
`timescale 1ns / 1ps
module vpbm_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  vpbm_pkg::cfg_t            cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [vpbm_pkg::ROW_W-1:0] s_pix_row,
    input  logic [vpbm_pkg::COL_W-1:0] s_pix_col,
    input  logic [7:0]                s_chan_a,
    input  logic [7:0]                s_chan_b,
    input  logic [7:0]                s_chan_c,
    input  logic [vpbm_pkg::SLOT_W-1:0] s_seed_slot,
    input  logic [7:0]                s_frame_mean,
    output logic                      q_valid,
    input  logic                      q_ready,
    output vpbm_pkg::entry_t          q_data
);
    import vpbm_pkg::*;

    logic       stage_valid_reg;
    entry_t     stage_reg;
    entry_t     cls;
    logic [8:0] w_sat, h_sat;
    logic [8:0] gate_lim;
    logic       border, gate;

    always_comb begin
        w_sat = ({1'b0, cfg.frame_width} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH)
                                                           : {1'b0, cfg.frame_width};
        h_sat = ({1'b0, cfg.frame_height} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT)
                                                             : {1'b0, cfg.frame_height};
        border = (s_pix_row == '0) || (s_pix_col == '0) ||
                 (9'(s_pix_row) + 9'd1 >= h_sat) || (9'(s_pix_col) + 9'd1 >= w_sat);
        gate_lim = {1'b0, s_frame_mean} + {1'b0, cfg.brightness_margin};
        gate = cfg.channel_mode && ({1'b0, s_chan_a} <= gate_lim);
        cls.row  = s_pix_row;
        cls.col  = s_pix_col;
        cls.slot = s_seed_slot;
        cls.px   = cfg.channel_mode ? {s_chan_c, s_chan_b, s_chan_a} : {16'd0, s_chan_a};
        if (s_opcode) begin
            cls.kind = K_SEED;
        end else if (border) begin
            cls.kind = K_BORDER;
        end else if (gate) begin
            cls.kind = K_GATE;
        end else begin
            cls.kind = K_TEST;
        end
    end

    assign s_ready = !stage_valid_reg || q_ready;
    assign q_valid = stage_valid_reg;
    assign q_data  = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            stage_valid_reg <= 1'b1;
        end else if (q_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_reg <= cls;
        end
    end

endmodule

// ----- design/vpbm_queue.sv -----
`timescale 1ns / 1ps
module vpbm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  vpbm_pkg::entry_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output vpbm_pkg::entry_t out_data
);
    import vpbm_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    entry_t             mem_q [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push, pop;

    assign in_ready  = count_reg < CNT_W'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_q[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_q[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- design/vpbm_back.sv -----
`timescale 1ns / 1ps
module vpbm_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  vpbm_pkg::cfg_t   cfg,
    input  logic             q_valid,
    output logic             q_ready,
    input  vpbm_pkg::entry_t q_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_is_foreground
);
    import vpbm_pkg::*;

    logic [PIX_W-1:0] store [MAX_SAMPLES * MAX_WIDTH * MAX_HEIGHT];

    state_t            state_reg, state_next;
    sel_t              sel_reg, sel_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PIX_W-1:0]  px_reg, px_next;
    logic              fg_reg, fg_next;
    logic [SLOT_W:0]   k_reg, k_next;
    logic [5:0]        matches_reg, matches_next;
    logic [8:0]        val_reg, val_next;
    logic [8:0]        mod_reg, mod_next;
    logic [7:0]        own_rep_reg, own_rep_next;
    logic [SLOT_W-1:0] own_slot_reg, own_slot_next;
    logic [7:0]        nbr_rep_reg, nbr_rep_next;
    logic [2:0]        nbr_pos_reg, nbr_pos_next;
    logic [SLOT_W-1:0] nbr_slot_reg, nbr_slot_next;
    logic [PIX_W-1:0]  rd_data_reg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [PIX_W-1:0]  mem_wdata;

    logic [8:0]        n_eff, iv_eff;
    logic [7:0]        da, db, dc;
    logic [9:0]        samp_dist;
    logic [6:0]        match_sum;
    logic [ROW_W-1:0]  nbr_row;
    logic [COL_W-1:0]  nbr_col;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always_comb begin
        if (cfg.num_samples == '0) begin
            n_eff = 9'd1;
        end else if ({3'd0, cfg.num_samples} > 9'(MAX_SAMPLES)) begin
            n_eff = 9'(MAX_SAMPLES);
        end else begin
            n_eff = {3'd0, cfg.num_samples};
        end
        iv_eff = (cfg.update_interval == '0) ? 9'd1 : {1'b0, cfg.update_interval};
        da = absdiff(px_reg[7:0], rd_data_reg[7:0]);
        db = absdiff(px_reg[15:8], rd_data_reg[15:8]);
        dc = absdiff(px_reg[23:16], rd_data_reg[23:16]);
        samp_dist = cfg.channel_mode ? ({2'd0, da} + {2'd0, db} + {2'd0, dc}) : {2'd0, da};
        match_sum = {1'b0, matches_reg} + ((samp_dist < cfg.match_radius) ? 7'd1 : 7'd0);
        // neighbor order: top row left to right, left, right, bottom row left to right
        nbr_row = (nbr_pos_reg < 3'd3) ? row_reg - 1'b1 :
                  (nbr_pos_reg < 3'd5) ? row_reg : row_reg + 1'b1;
        unique case (nbr_pos_reg)
            3'd0, 3'd3, 3'd5: nbr_col = col_reg - 1'b1;
            3'd1, 3'd6:       nbr_col = col_reg;
            default:          nbr_col = col_reg + 1'b1;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        px_next       = px_reg;
        fg_next       = fg_reg;
        k_next        = k_reg;
        matches_next  = matches_reg;
        val_next      = val_reg;
        mod_next      = mod_reg;
        own_rep_next  = own_rep_reg;
        own_slot_next = own_slot_reg;
        nbr_rep_next  = nbr_rep_reg;
        nbr_pos_next  = nbr_pos_reg;
        nbr_slot_next = nbr_slot_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = px_reg;
        mem_re    = 1'b0;
        mem_raddr = {row_reg, col_reg, k_reg[SLOT_W-1:0]};
        q_ready   = 1'b0;
        m_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                q_ready  = 1'b1;
                row_next = q_data.row;
                col_next = q_data.col;
                px_next  = q_data.px;
                fg_next  = 1'b0;
                if (q_valid) begin
                    unique case (q_data.kind)
                        K_SEED: begin
                            mem_we    = 1'b1;
                            mem_waddr = {q_data.row, q_data.col, q_data.slot};
                            mem_wdata = q_data.px;
                        end
                        K_BORDER: state_next = S_OUT;
                        K_GATE: begin
                            val_next   = {1'b0, own_rep_reg} + 9'd1;
                            mod_next   = iv_eff;
                            sel_next   = SEL_OWN_REP;
                            state_next = S_MOD;
                        end
                        default: begin
                            if (cfg.min_matches == '0) begin
                                val_next   = {1'b0, own_rep_reg} + 9'd1;
                                mod_next   = iv_eff;
                                sel_next   = SEL_OWN_REP;
                                state_next = S_MOD;
                            end else begin
                                k_next       = '0;
                                matches_next = '0;
                                state_next   = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                matches_next = match_sum[5:0];
                if (match_sum >= {1'b0, cfg.min_matches}) begin
                    val_next   = {1'b0, own_rep_reg} + 9'd1;
                    mod_next   = iv_eff;
                    sel_next   = SEL_OWN_REP;
                    state_next = S_MOD;
                end else if (9'(k_reg) + 9'd1 >= n_eff) begin
                    fg_next    = 1'b1;
                    state_next = S_OUT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_MOD: begin
                // wrap by repeated subtraction, only loops after a config change
                if (val_reg >= mod_reg) begin
                    val_next = val_reg - mod_reg;
                end else begin
                    unique case (sel_reg)
                        SEL_OWN_REP: begin
                            own_rep_next = val_reg[7:0];
                            if (val_reg == '0) begin
                                val_next = 9'(own_slot_reg) + 9'd1;
                                mod_next = n_eff;
                                sel_next = SEL_OWN_SLOT;
                            end else begin
                                val_next = {1'b0, nbr_rep_reg} + 9'd1;
                                mod_next = iv_eff;
                                sel_next = SEL_NBR_REP;
                            end
                        end
                        SEL_OWN_SLOT: begin
                            own_slot_next = val_reg[SLOT_W-1:0];
                            mem_we    = 1'b1;
                            mem_waddr = {row_reg, col_reg, val_reg[SLOT_W-1:0]};
                            val_next  = {1'b0, nbr_rep_reg} + 9'd1;
                            mod_next  = iv_eff;
                            sel_next  = SEL_NBR_REP;
                        end
                        SEL_NBR_REP: begin
                            nbr_rep_next = val_reg[7:0];
                            if (val_reg == '0) begin
                                nbr_pos_next = nbr_pos_reg + 1'b1;
                                val_next = 9'(nbr_slot_reg) + 9'd1;
                                mod_next = n_eff;
                                sel_next = SEL_NBR_SLOT;
                            end else begin
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            nbr_slot_next = val_reg[SLOT_W-1:0];
                            mem_we     = 1'b1;
                            mem_waddr  = {nbr_row, nbr_col, val_reg[SLOT_W-1:0]};
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_is_foreground = fg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            own_rep_reg  <= '0;
            own_slot_reg <= '0;
            nbr_rep_reg  <= '0;
            nbr_pos_reg  <= '0;
            nbr_slot_reg <= '0;
        end else begin
            state_reg    <= state_next;
            own_rep_reg  <= own_rep_next;
            own_slot_reg <= own_slot_next;
            nbr_rep_reg  <= nbr_rep_next;
            nbr_pos_reg  <= nbr_pos_next;
            nbr_slot_reg <= nbr_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg     <= sel_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        px_reg      <= px_next;
        fg_reg      <= fg_next;
        k_reg       <= k_next;
        matches_reg <= matches_next;
        val_reg     <= val_next;
        mod_reg     <= mod_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= store[mem_raddr];
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import vpbm_pkg::*;

    localparam int WDOG_LIMIT = 4000;
    localparam int SETTLE = 120;
    localparam int REGION = 4;

    typedef struct {
        bit        op;
        int        row;
        int        col;
        bit [7:0]  a;
        bit [7:0]  b;
        bit [7:0]  c;
        int        slot;
        bit [7:0]  mean;
        int        fixed_fg;   // -1: take the predicted value
    } pix_item_t;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 0;
    logic                  s_ready;
    logic                  s_opcode = 0;
    logic [ROW_W-1:0]      s_pix_row = '0;
    logic [COL_W-1:0]      s_pix_col = '0;
    logic [7:0]            s_chan_a = '0;
    logic [7:0]            s_chan_b = '0;
    logic [7:0]            s_chan_c = '0;
    logic [SLOT_W-1:0]     s_seed_slot = '0;
    logic [7:0]            s_frame_mean = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    logic                  m_is_foreground;

    vibe_pixel_background_model_top uut (.*);

    always #4 aclk = ~aclk;

    // model copy
    bit [23:0] samples [int];
    int n_samp = 20, radius = 20, min_match = 2, interval = 16;
    int mode = 1, fwidth = 128, fheight = 128, margin = 20;
    int own_cnt, own_slot, nbr_cnt, nbr_pos, nbr_slot;
    bit [23:0] base_px [1:REGION][1:REGION];

    bit fg_q [$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    int rx_stall = 0;

    function automatic int sample_addr(int r, int c, int k);
        return (r * MAX_WIDTH + c) * MAX_SAMPLES + k;
    endfunction

    function automatic int absd(int x, int y);
        return x > y ? x - y : y - x;
    endfunction

    function automatic bit [7:0] jitter(bit [7:0] v);
        int x;
        x = int'(v) + $urandom_range(0, 12) - 6;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return x[7:0];
    endfunction

    // classify one beat and apply the sample refresh; returns -1 for a seed
    function automatic int classify(pix_item_t it);
        bit [23:0] px, s;
        int n, iv, match_cnt, d, y, x;
        bit bg;
        px = {8'h0, 8'h0, it.a};
        if (mode == 1) px = {it.c, it.b, it.a};
        n = n_samp < 1 ? 1 : (n_samp > MAX_SAMPLES ? MAX_SAMPLES : n_samp);
        iv = interval == 0 ? 1 : interval;
        if (it.op) begin
            samples[sample_addr(it.row, it.col, it.slot)] = px;
            return -1;
        end
        if (it.row == 0 || it.col == 0 || it.row + 1 >= fheight || it.col + 1 >= fwidth)
            return 0;
        if (mode == 1 && int'(it.a) <= int'(it.mean) + margin) begin
            bg = 1;
        end else begin
            match_cnt = 0;
            for (int k = 0; k < n && match_cnt < min_match; k++) begin
                s = samples.exists(sample_addr(it.row, it.col, k)) ?
                    samples[sample_addr(it.row, it.col, k)] : 24'h0;
                d = absd(px[7:0], s[7:0]);
                if (mode == 1) d += absd(px[15:8], s[15:8]) + absd(px[23:16], s[23:16]);
                if (d < radius) match_cnt++;
            end
            bg = match_cnt >= min_match;
        end
        if (!bg) return 1;
        own_cnt = (own_cnt + 1) % iv;
        if (own_cnt == 0) begin
            own_slot = (own_slot + 1) % n;
            samples[sample_addr(it.row, it.col, own_slot)] = px;
        end
        nbr_cnt = (nbr_cnt + 1) % iv;
        if (nbr_cnt == 0) begin
            nbr_pos = (nbr_pos + 1) % 8;
            nbr_slot = (nbr_slot + 1) % n;
            // neighbor order: top-left, top, top-right, left, right, bottom-left, ...
            y = it.row + (nbr_pos < 3 ? -1 : (nbr_pos < 5 ? 0 : 1));
            x = it.col + (nbr_pos == 0 || nbr_pos == 3 || nbr_pos == 5 ? -1 :
                          (nbr_pos == 1 || nbr_pos == 6 ? 0 : 1));
            samples[sample_addr(y, x, nbr_slot)] = px;
        end
        return 0;
    endfunction

    task automatic send_beat(pix_item_t it, bit last);
        int r, g;
        s_valid <= 1;
        s_opcode <= it.op;
        s_pix_row <= it.row[ROW_W-1:0];
        s_pix_col <= it.col[COL_W-1:0];
        s_chan_a <= it.a;
        s_chan_b <= it.b;
        s_chan_c <= it.c;
        s_seed_slot <= it.slot[SLOT_W-1:0];
        s_frame_mean <= it.mean;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = classify(it);
        if (r >= 0) fg_q.push_back(it.fixed_fg >= 0 ? it.fixed_fg[0] : r[0]);
        g = quiet ? 0 : $urandom_range(0, 19);
        if (g > 0 || last) s_valid <= 0;
        repeat (g) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            REG_NUM_SAMPLES:   n_samp = val;
            REG_MATCH_RADIUS:  radius = val;
            REG_MIN_MATCHES:   min_match = val;
            REG_UPD_INTERVAL:  interval = val;
            REG_CHANNEL_MODE:  mode = val;
            REG_FRAME_WIDTH:   fwidth = val;
            REG_FRAME_HEIGHT:  fheight = val;
            REG_BRIGHT_MARGIN: margin = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (fg_q.size() != 0) @(posedge aclk);
        // seeds give no beat, let the back end finish them
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(int n, int rad, int mm, int iv, int md, int w, int h, int mg);
        drain();
        write_reg(REG_NUM_SAMPLES, n);
        write_reg(REG_MATCH_RADIUS, rad);
        write_reg(REG_MIN_MATCHES, mm);
        write_reg(REG_UPD_INTERVAL, iv);
        write_reg(REG_CHANNEL_MODE, md);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BRIGHT_MARGIN, mg);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    function automatic pix_item_t region_seed(int r, int c, int k);
        pix_item_t it;
        it = '{1, r, c, jitter(base_px[r][c][7:0]), jitter(base_px[r][c][15:8]),
               jitter(base_px[r][c][23:16]), k, 8'($urandom_range(0, 255)), -1};
        return it;
    endfunction

    function automatic pix_item_t random_item();
        pix_item_t it;
        int sel, k;
        bit [23:0] s;
        sel = $urandom_range(0, 99);
        it = '{0, $urandom_range(1, REGION), $urandom_range(1, REGION),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)),
               $urandom_range(0, 31), 8'($urandom_range(0, 255)), -1};
        if ($urandom_range(0, 1)) it.mean = 8'($urandom_range(0, 60));
        if (sel < 8) begin
            it = region_seed(it.row, it.col, $urandom_range(0, 31));
        end else if (sel < 14) begin
            it.op = 1;
            it.row = $urandom_range(0, 127);
            it.col = $urandom_range(0, 127);
        end else if (sel < 24) begin
            case ($urandom_range(0, 3))
                0: begin it.row = 0; it.col = $urandom_range(0, 127); end
                1: begin it.col = 0; it.row = $urandom_range(0, 127); end
                2: begin it.row = $urandom_range(127, fheight - 1); it.col = $urandom_range(0, 127); end
                default: begin
                    it.col = $urandom_range(127, fwidth - 1);
                    it.row = $urandom_range(0, 127);
                end
            endcase
        end else if (sel < 85) begin
            // near a stored sample so the match count moves around
            k = $urandom_range(0, 31);
            s = samples[sample_addr(it.row, it.col, k)];
            it.a = jitter(s[7:0]);
            it.b = jitter(s[15:8]);
            it.c = jitter(s[23:16]);
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            quiet = (i % 100) < 20;
            send_beat(random_item(), i == count - 1);
        end
        quiet = 0;
    endtask

    pix_item_t directed [] = '{
        '{0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 0},
        '{0, 127, 127, 8'hFF, 8'h00, 8'hFF, 31, 8'h00, 0},
        '{0, 0, 64, 8'h80, 8'h80, 8'h80, 0, 8'h10, 0},
        '{0, 64, 0, 8'hF0, 8'h0F, 8'hAA, 0, 8'h10, 0},
        '{0, 127, 5, 8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 0},
        '{0, 5, 127, 8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 0},
        '{0, 2, 2, 8'h00, 8'hFF, 8'hFF, 0, 8'h00, 0},
        '{0, 3, 3, 8'hFF, 8'h12, 8'h34, 0, 8'hFF, 0},
        '{0, 2, 3, 8'd20, 8'h55, 8'hAA, 0, 8'h00, 0},
        '{0, 3, 2, 8'd30, 8'h00, 8'h00, 0, 8'd10, 0},
        '{1, 127, 127, 8'hFF, 8'hFF, 8'hFF, 31, 8'hFF, -1},
        '{1, 0, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, -1},
        '{1, 85, 42, 8'hAA, 8'h55, 8'hAA, 21, 8'h55, -1},
        '{1, 42, 85, 8'h55, 8'hAA, 8'h55, 10, 8'hAA, -1},
        '{0, 126, 64, 8'h7F, 8'h01, 8'hFE, 0, 8'hFF, 0},
        '{0, 64, 126, 8'h01, 8'hFE, 8'h7F, 0, 8'hFF, 0}
    };

    // result side: random stalls per beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            rx_stall = 0;
        end else if (m_valid && m_ready) begin
            if (fg_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat fg=%0b", m_is_foreground);
            end else begin
                if (m_is_foreground !== fg_q[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("is_foreground mismatch: expected %0b got %0b",
                                 fg_q[0], m_is_foreground);
                end
                void'(fg_q.pop_front());
            end
            rx_stall = quiet ? 0 : $urandom_range(0, 19);
            m_ready <= (rx_stall == 0);
        end else if (!m_ready) begin
            if (rx_stall > 0) rx_stall--;
            if (rx_stall == 0) m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("vibe_pixel_background_model_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (directed[i]) send_beat(directed[i], i == directed.size() - 1);

        // every slot of every pixel in the test region gets a sample before the random phases classify it
        for (int r = 1; r <= REGION; r++)
            for (int c = 1; c <= REGION; c++)
                base_px[r][c] = 24'($urandom());
        for (int r = 1; r <= REGION; r++)
            for (int c = 1; c <= REGION; c++)
                for (int k = 0; k < MAX_SAMPLES; k++)
                    send_beat(region_seed(r, c, k), r == REGION && c == REGION && k == 31);

        random_phase(190);
        set_config(32, 30, 3, 1, 0, 8, 8, 0);
        random_phase(190);
        set_config(1, 766, 1, 255, 1, 128, 128, 255);
        random_phase(190);
        set_config(8, 0, 0, 3, 1, 3, 3, 0);
        random_phase(190);
        set_config(32, 40, 32, 2, 1, 6, 6, 10);
        random_phase(190);
        set_config(5, 15, 2, 7, 0, 128, 5, 100);
        random_phase(190);
        set_config(16, 60, 4, 5, 1, 5, 128, 0);
        random_phase(190);

        while (fg_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && fg_q.size() == 0) begin
            $display("vibe_pixel_background_model_top test passed");
        end else begin
            $display("vibe_pixel_background_model_top test failed");
        end
        $finish;
    end
endmodule
